// ----- sv/vector_length_fast_isqrt_macros.svh -----
// assertion helpers shared by the vector length datapath
`ifndef VECTOR_LENGTH_FAST_ISQRT_MACROS_SVH
`define VECTOR_LENGTH_FAST_ISQRT_MACROS_SVH

// same-cycle implication, quiet during reset
`define VLFI_ASSERT_IMP(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define VLFI_ASSERT_NXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- sv/vlfi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package vlfi_pkg;

   localparam logic [31:0] ISQRT_MAGIC  = 32'h5F3759D5;
   localparam logic [31:0] HALF_BITS    = 32'h3F000000;
   localparam logic [31:0] THREE_HALVES = 32'h3FC00000;
   localparam logic [31:0] CANON_NAN    = 32'h7FC00000;

   localparam logic CMD_VEC3 = 1'b1;

   localparam int LANES      = 3;
   localparam int TOP_STAGES = 27;
   localparam int CMD_TAPS   = 3;
   localparam int ZZ_TAPS    = 4;
   localparam int EST_TAPS   = 13;
   localparam int EST_TAP_P  = 2;
   localparam int EST_TAP_Q  = 5;
   localparam int EST_TAP_R  = EST_TAPS - 1;
   localparam int QBITS      = 28;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = QBITS / DIV_STEPS;

   typedef enum logic [1:0] {FK_NUM, FK_ZERO, FK_INF, FK_NAN} fkind_type;

   typedef struct packed {
      fkind_type          kind;
      logic               sgn;
      logic signed [9:0]  exp;
      logic [23:0]        man;
   } unp_type;

   typedef struct packed {
      fkind_type          kind;
      logic               sgn;
      logic signed [10:0] exp;
      logic [23:0]        ma;
      logic [23:0]        mb;
   } mul1_type;

   typedef struct packed {
      fkind_type          kind;
      logic               sgn;
      logic signed [10:0] exp;
      logic [47:0]        prod;
   } mul2_type;

   typedef struct packed {
      fkind_type          kind;
      logic               sgn;
      logic               sub;
      logic signed [9:0]  exp;
      logic [4:0]         d;
      logic [23:0]        ma;
      logic [23:0]        mb;
   } add1_type;

   typedef struct packed {
      fkind_type          kind;
      logic               sgn;
      logic signed [9:0]  exp;
      logic [27:0]        sum;
   } add2_type;

   typedef struct packed {
      fkind_type          kind;
      logic               sgn;
      logic signed [11:0] exp;
      logic [26:0]        sig;
   } add3_type;

   typedef struct packed {
      fkind_type          kind;
      logic               sgn;
      logic signed [9:0]  exp;
      logic [23:0]        man;
      logic [24:0]        rem;
      logic [QBITS-1:0]   q;
   } div_type;

   function automatic logic [4:0] lzc27(input logic [26:0] v);
      logic [4:0] n;
      logic       hit;
      n   = 5'd27;
      hit = 1'b0;
      for (int i = 26; i >= 0; i--) begin
         if (!hit && v[i]) begin
            n   = 5'(26 - i);
            hit = 1'b1;
         end
      end
      return n;
   endfunction

   // mantissa normalized to bit 23, value = man * 2^(exp-23)
   function automatic unp_type unpack(input logic [31:0] b);
      unp_type    u;
      logic [7:0] e;
      logic [22:0] f;
      logic [4:0] lz;
      e      = b[30:23];
      f      = b[22:0];
      lz     = lzc27({f, 1'b0, 3'b111});
      u.sgn  = b[31];
      u.kind = FK_NUM;
      u.exp  = '0;
      u.man  = '0;
      if (e == 8'hFF) begin
         u.kind = (f != '0) ? FK_NAN : FK_INF;
      end else if (e == 8'd0) begin
         if (f == '0) begin
            u.kind = FK_ZERO;
         end else begin
            u.man = {f, 1'b0} << lz;
            u.exp = -10'sd127 - $signed({5'd0, lz});
         end
      end else begin
         u.man = {1'b1, f};
         u.exp = $signed({2'b00, e}) - 10'sd127;
      end
      return u;
   endfunction

   function automatic logic [31:0] pack_special(input fkind_type kind, input logic sgn);
      logic [31:0] res;
      case (kind)
         FK_NAN:  res = CANON_NAN;
         FK_INF:  res = {sgn, 8'hFF, 23'd0};
         default: res = {sgn, 31'd0};
      endcase
      return res;
   endfunction

   // sig has its leading one at bit 26, value = sig * 2^(e-26)
   function automatic logic [31:0] round_pack(input logic sgn, input logic signed [11:0] e,
                                              input logic [26:0] sig);
      logic [26:0]        s;
      logic signed [11:0] diff;
      logic signed [11:0] be;
      logic [4:0]         sh;
      logic               st;
      logic               inc;
      logic               sub;
      logic [24:0]        m;
      logic [31:0]        res;
      s    = sig;
      sub  = 1'b0;
      sh   = '0;
      st   = 1'b0;
      diff = -12'sd126 - e;
      if (e < -12'sd126) begin
         sub = 1'b1;
         sh  = (diff > 12'sd27) ? 5'd27 : diff[4:0];
         st  = |(s & ((27'd1 << sh) - 27'd1));
         s   = (s >> sh) | {26'd0, st};
      end
      inc = s[2] & (s[3] | s[1] | s[0]);
      m   = {1'b0, s[26:3]} + {24'd0, inc};
      be  = e + 12'sd127 + $signed({11'd0, m[24]});
      if (sub) begin
         res = {sgn, 7'd0, m[23], m[22:0]};
      end else if (be >= 12'sd255) begin
         res = {sgn, 8'hFF, 23'd0};
      end else begin
         res = {sgn, be[7:0], m[22:0]};
      end
      return res;
   endfunction

   function automatic mul1_type mul_s1(input logic [31:0] a, input logic [31:0] b);
      unp_type  ua;
      unp_type  ub;
      mul1_type m;
      ua     = unpack(a);
      ub     = unpack(b);
      m.sgn  = ua.sgn ^ ub.sgn;
      m.exp  = {ua.exp[9], ua.exp} + {ub.exp[9], ub.exp};
      m.ma   = ua.man;
      m.mb   = ub.man;
      if (ua.kind == FK_NAN || ub.kind == FK_NAN ||
          (ua.kind == FK_INF && ub.kind == FK_ZERO) ||
          (ua.kind == FK_ZERO && ub.kind == FK_INF)) begin
         m.kind = FK_NAN;
      end else if (ua.kind == FK_INF || ub.kind == FK_INF) begin
         m.kind = FK_INF;
      end else if (ua.kind == FK_ZERO || ub.kind == FK_ZERO) begin
         m.kind = FK_ZERO;
      end else begin
         m.kind = FK_NUM;
      end
      return m;
   endfunction

   function automatic mul2_type mul_s2(input mul1_type m);
      mul2_type p;
      p.kind = m.kind;
      p.sgn  = m.sgn;
      p.exp  = m.exp;
      p.prod = {24'd0, m.ma} * {24'd0, m.mb};
      return p;
   endfunction

   function automatic logic [31:0] mul_s3(input mul2_type p);
      logic signed [11:0] e;
      logic [31:0]        res;
      e = {p.exp[10], p.exp};
      if (p.kind != FK_NUM) begin
         res = pack_special(p.kind, p.sgn);
      end else if (p.prod[47]) begin
         res = round_pack(p.sgn, e + 12'sd1, {p.prod[47:22], |p.prod[21:0]});
      end else begin
         res = round_pack(p.sgn, e, {p.prod[46:21], |p.prod[20:0]});
      end
      return res;
   endfunction

   function automatic add1_type add_s1(input logic [31:0] a, input logic [31:0] b);
      logic               swap;
      logic [31:0]        hi;
      logic [31:0]        lo;
      logic [7:0]         eh;
      logic [7:0]         el;
      logic               nh;
      logic               nl;
      logic               ih;
      logic               il;
      logic signed [9:0]  xh;
      logic signed [9:0]  xl;
      logic signed [9:0]  dd;
      add1_type           r;
      swap = a[30:0] < b[30:0];
      hi   = swap ? b : a;
      lo   = swap ? a : b;
      eh   = hi[30:23];
      el   = lo[30:23];
      nh   = (eh == 8'hFF) && (hi[22:0] != '0);
      nl   = (el == 8'hFF) && (lo[22:0] != '0);
      ih   = (eh == 8'hFF) && (hi[22:0] == '0);
      il   = (el == 8'hFF) && (lo[22:0] == '0);
      xh   = (eh == 8'd0) ? -10'sd126 : $signed({2'b00, eh}) - 10'sd127;
      xl   = (el == 8'd0) ? -10'sd126 : $signed({2'b00, el}) - 10'sd127;
      dd   = xh - xl;
      r.d   = (dd > 10'sd27) ? 5'd27 : dd[4:0];
      r.ma  = {eh != 8'd0, hi[22:0]};
      r.mb  = {el != 8'd0, lo[22:0]};
      r.exp = xh;
      r.sub = hi[31] ^ lo[31];
      r.sgn = hi[31];
      r.kind = FK_NUM;
      if (nh || nl) begin
         r.kind = FK_NAN;
      end else if (ih) begin
         r.kind = (il && r.sub) ? FK_NAN : FK_INF;
      end else if (hi[30:0] == '0) begin
         r.kind = FK_ZERO;
         r.sgn  = a[31] & b[31];
      end
      return r;
   endfunction

   function automatic add2_type add_s2(input add1_type r);
      logic [26:0] av;
      logic [26:0] bf;
      logic [26:0] bv;
      logic        st;
      add2_type    o;
      av    = {r.ma, 3'b000};
      bf    = {r.mb, 3'b000};
      st    = |(bf & ((27'd1 << r.d) - 27'd1));
      bv    = (bf >> r.d) | {26'd0, st};
      o.kind = r.kind;
      o.sgn  = r.sgn;
      o.exp  = r.exp;
      o.sum  = r.sub ? ({1'b0, av} - {1'b0, bv}) : ({1'b0, av} + {1'b0, bv});
      return o;
   endfunction

   function automatic add3_type add_s3(input add2_type r);
      logic [4:0]         lz;
      logic signed [11:0] e;
      add3_type           o;
      lz     = lzc27(r.sum[26:0]);
      e      = {{2{r.exp[9]}}, r.exp};
      o.kind = r.kind;
      o.sgn  = r.sgn;
      // exact cancellation rounds to +0
      if (r.kind == FK_NUM && r.sum == '0) begin
         o.kind = FK_ZERO;
         o.sgn  = 1'b0;
      end
      if (r.sum[27]) begin
         o.sig = {r.sum[27:2], r.sum[1] | r.sum[0]};
         o.exp = e + 12'sd1;
      end else begin
         o.sig = r.sum[26:0] << lz;
         o.exp = e - $signed({7'd0, lz});
      end
      return o;
   endfunction

   function automatic logic [31:0] add_s4(input add3_type r);
      logic [31:0] res;
      if (r.kind == FK_NUM) begin
         res = round_pack(r.sgn, r.exp, r.sig);
      end else begin
         res = pack_special(r.kind, r.sgn);
      end
      return res;
   endfunction

   function automatic div_type div_init(input logic [31:0] b);
      unp_type u;
      div_type d;
      u      = unpack(b);
      d.kind = u.kind;
      d.sgn  = u.sgn;
      d.exp  = u.exp;
      d.man  = u.man;
      d.rem  = 25'h0800000;
      d.q    = '0;
      return d;
   endfunction

   function automatic div_type div_step(input div_type d);
      div_type r;
      logic    ge;
      r = d;
      for (int i = 0; i < DIV_STEPS; i++) begin
         ge = r.rem >= {1'b0, r.man};
         if (ge) begin
            r.rem = r.rem - {1'b0, r.man};
         end
         r.q   = {r.q[QBITS-2:0], ge};
         r.rem = r.rem << 1;
      end
      return r;
   endfunction

   // 1/r from the finished quotient of 2^(23+QBITS-1) / man
   function automatic logic [31:0] div_final(input div_type d);
      logic               st;
      logic signed [11:0] e;
      logic [31:0]        res;
      st = d.rem != '0;
      e  = {{2{d.exp[9]}}, d.exp};
      case (d.kind)
         FK_NAN:  res = CANON_NAN;
         FK_INF:  res = {d.sgn, 31'd0};
         FK_ZERO: res = {d.sgn, 8'hFF, 23'd0};
         default: begin
            if (d.q[QBITS-1]) begin
               res = round_pack(d.sgn, -e, d.q[QBITS-1:1]);
            end else begin
               res = round_pack(d.sgn, -12'sd1 - e, {d.q[QBITS-2:1], d.q[0] | st});
            end
         end
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- sv/vlfi_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface vlfi_req_if;
   logic        valid;
   logic        ready;
   logic [0:0]  command;
   logic [31:0] x_bits;
   logic [31:0] y_bits;
   logic [31:0] z_bits;

   modport source (output valid, command, x_bits, y_bits, z_bits, input ready);
   modport sink   (input valid, command, x_bits, y_bits, z_bits, output ready);
endinterface

interface vlfi_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] length_bits;

   modport source (output valid, length_bits, input ready);
   modport sink   (input valid, length_bits, output ready);
endinterface

`default_nettype wire

// ----- sv/vlfi_recip.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "vector_length_fast_isqrt_macros.svh"

module vlfi_recip (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [31:0] in_bits,
   output logic        out_valid,
   output logic [31:0] out_bits
);

   vlfi_pkg::div_type div_ff [vlfi_pkg::DIV_STAGES+1];
   logic [vlfi_pkg::DIV_STAGES:0] vld_ff;
   logic [vlfi_pkg::DIV_STAGES:0] vld_in;
   logic        out_valid_ff;
   logic [31:0] out_bits_ff;

   assign vld_in = {vld_ff[vlfi_pkg::DIV_STAGES-1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= vld_in;
         out_valid_ff <= vld_ff[vlfi_pkg::DIV_STAGES];
      end
   end

   // two quotient bits per stage
   always_ff @(posedge clock) begin
      if (en) begin
         div_ff[0] <= vlfi_pkg::div_init(in_bits);
         for (int k = 0; k < vlfi_pkg::DIV_STAGES; k++) begin
            div_ff[k+1] <= vlfi_pkg::div_step(div_ff[k]);
         end
         out_bits_ff <= vlfi_pkg::div_final(div_ff[vlfi_pkg::DIV_STAGES]);
      end
   end

   assign out_valid = out_valid_ff;
   assign out_bits  = out_bits_ff;

   `VLFI_ASSERT_NXT(a_recip_frozen, !en, $stable(out_valid_ff) && $stable(out_bits_ff), "output moved during stall")
   `VLFI_ASSERT_NXT(a_recip_enter, in_valid && en, vld_ff[0], "accepted word lost at divider entry")
   `VLFI_ASSERT_IMP(a_recip_nan, out_valid_ff && out_bits_ff[30:23] == 8'hFF && out_bits_ff[22:0] != 23'd0, out_bits_ff == vlfi_pkg::CANON_NAN, "nan not canonical")

endmodule

`default_nettype wire

// ----- sv/vector_length_fast_isqrt.sv -----
// vector_length_fast_isqrt: approximate length of a 2- or 3-component float32 vector.
// req_chan carries command (0: x,y; 1: x,y,z) and the three component bit patterns;
// rsp_chan returns length_bits, one word per request word, in order.
// Both channels use valid/ready; a word moves on a clock edge with both high.
// Datapath: squares, two adds, the 0x5F3759D5 estimate with one Newton step,
// then a reciprocal. Every operation rounds to nearest even, subnormals kept,
// nan results come out as 0x7FC00000.
// Throughput: one vector per cycle while the output is not held; 27 stages of
// float mul/add feed a 16-stage divider whose step stages retire two quotient
// bits each.
// When the output word is valid and not taken, the whole pipeline holds and
// req_chan.ready is low; nothing is dropped or repeated.
// Reset (synchronous, active high) clears all stage valid bits; no other state.
`timescale 1ns / 1ps
`default_nettype none

`include "vector_length_fast_isqrt_macros.svh"

module vector_length_fast_isqrt (
   input  logic       clock,
   input  logic       reset,
   vlfi_req_if.sink   req_chan,
   vlfi_rsp_if.source rsp_chan
);

   logic        adv;
   logic        out_valid;
   logic [31:0] out_bits;

   logic [vlfi_pkg::TOP_STAGES-1:0] vld_ff;
   logic [vlfi_pkg::TOP_STAGES-1:0] vld_in;

   vlfi_pkg::mul1_type sq1_ff [vlfi_pkg::LANES];
   vlfi_pkg::mul2_type sq2_ff [vlfi_pkg::LANES];
   logic [31:0]        sq3_ff [vlfi_pkg::LANES];
   logic [31:0]        comp_in [vlfi_pkg::LANES];
   logic               cmd_d_ff [vlfi_pkg::CMD_TAPS];

   vlfi_pkg::add1_type a1_ff;
   vlfi_pkg::add2_type a2_ff;
   vlfi_pkg::add3_type a3_ff;
   logic [31:0]        sa_ff;
   logic [31:0]        zz_in;
   logic [31:0]        zz_d_ff [vlfi_pkg::ZZ_TAPS];

   vlfi_pkg::add1_type b1_ff;
   vlfi_pkg::add2_type b2_ff;
   vlfi_pkg::add3_type b3_ff;
   logic [31:0]        s_ff;

   logic [31:0]        est_in;
   logic [31:0]        est_d_ff [vlfi_pkg::EST_TAPS];

   vlfi_pkg::mul1_type h1_ff;
   vlfi_pkg::mul2_type h2_ff;
   logic [31:0]        half_ff;
   vlfi_pkg::mul1_type p1_ff;
   vlfi_pkg::mul2_type p2_ff;
   logic [31:0]        p_ff;
   vlfi_pkg::mul1_type q1_ff;
   vlfi_pkg::mul2_type q2_ff;
   logic [31:0]        q_ff;
   vlfi_pkg::add1_type c1_ff;
   vlfi_pkg::add2_type c2_ff;
   vlfi_pkg::add3_type c3_ff;
   logic [31:0]        corr_ff;
   vlfi_pkg::mul1_type r1_ff;
   vlfi_pkg::mul2_type r2_ff;
   logic [31:0]        r_ff;

   assign adv            = !out_valid || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign vld_in         = {vld_ff[vlfi_pkg::TOP_STAGES-2:0], req_chan.valid};

   assign comp_in[0] = req_chan.x_bits;
   assign comp_in[1] = req_chan.y_bits;
   assign comp_in[2] = req_chan.z_bits;

   // two-component vectors add +0 in place of z*z
   assign zz_in  = (cmd_d_ff[vlfi_pkg::CMD_TAPS-1] == vlfi_pkg::CMD_VEC3) ? sq3_ff[2] : 32'd0;
   // arithmetic shift right by one, then wrap-around subtract
   assign est_in = vlfi_pkg::ISQRT_MAGIC - {s_ff[31], s_ff[31:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < vlfi_pkg::LANES; l++) begin
            sq1_ff[l] <= vlfi_pkg::mul_s1(comp_in[l], comp_in[l]);
            sq2_ff[l] <= vlfi_pkg::mul_s2(sq1_ff[l]);
            sq3_ff[l] <= vlfi_pkg::mul_s3(sq2_ff[l]);
         end
         cmd_d_ff[0] <= req_chan.command[0];
         for (int k = 1; k < vlfi_pkg::CMD_TAPS; k++) begin
            cmd_d_ff[k] <= cmd_d_ff[k-1];
         end

         // x*x + y*y
         a1_ff <= vlfi_pkg::add_s1(sq3_ff[0], sq3_ff[1]);
         a2_ff <= vlfi_pkg::add_s2(a1_ff);
         a3_ff <= vlfi_pkg::add_s3(a2_ff);
         sa_ff <= vlfi_pkg::add_s4(a3_ff);
         zz_d_ff[0] <= zz_in;
         for (int k = 1; k < vlfi_pkg::ZZ_TAPS; k++) begin
            zz_d_ff[k] <= zz_d_ff[k-1];
         end

         // + z*z
         b1_ff <= vlfi_pkg::add_s1(sa_ff, zz_d_ff[vlfi_pkg::ZZ_TAPS-1]);
         b2_ff <= vlfi_pkg::add_s2(b1_ff);
         b3_ff <= vlfi_pkg::add_s3(b2_ff);
         s_ff  <= vlfi_pkg::add_s4(b3_ff);

         est_d_ff[0] <= est_in;
         for (int k = 1; k < vlfi_pkg::EST_TAPS; k++) begin
            est_d_ff[k] <= est_d_ff[k-1];
         end

         h1_ff   <= vlfi_pkg::mul_s1(vlfi_pkg::HALF_BITS, s_ff);
         h2_ff   <= vlfi_pkg::mul_s2(h1_ff);
         half_ff <= vlfi_pkg::mul_s3(h2_ff);

         p1_ff <= vlfi_pkg::mul_s1(half_ff, est_d_ff[vlfi_pkg::EST_TAP_P]);
         p2_ff <= vlfi_pkg::mul_s2(p1_ff);
         p_ff  <= vlfi_pkg::mul_s3(p2_ff);

         q1_ff <= vlfi_pkg::mul_s1(p_ff, est_d_ff[vlfi_pkg::EST_TAP_Q]);
         q2_ff <= vlfi_pkg::mul_s2(q1_ff);
         q_ff  <= vlfi_pkg::mul_s3(q2_ff);

         // 1.5 - q as 1.5 + (-q)
         c1_ff   <= vlfi_pkg::add_s1(vlfi_pkg::THREE_HALVES, {~q_ff[31], q_ff[30:0]});
         c2_ff   <= vlfi_pkg::add_s2(c1_ff);
         c3_ff   <= vlfi_pkg::add_s3(c2_ff);
         corr_ff <= vlfi_pkg::add_s4(c3_ff);

         r1_ff <= vlfi_pkg::mul_s1(est_d_ff[vlfi_pkg::EST_TAP_R], corr_ff);
         r2_ff <= vlfi_pkg::mul_s2(r1_ff);
         r_ff  <= vlfi_pkg::mul_s3(r2_ff);
      end
   end

   vlfi_recip u_recip (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (vld_ff[vlfi_pkg::TOP_STAGES-1]),
      .in_bits   (r_ff),
      .out_valid (out_valid),
      .out_bits  (out_bits)
   );

   assign rsp_chan.valid       = out_valid;
   assign rsp_chan.length_bits = out_bits;

   `VLFI_ASSERT_IMP(a_no_take_when_full, out_valid && !rsp_chan.ready, !req_chan.ready, "input taken while output stalled")
   `VLFI_ASSERT_NXT(a_stage_valids_hold, !adv, $stable(vld_ff), "stage valids moved during stall")
   `VLFI_ASSERT_NXT(a_take_enters_pipe, req_chan.valid && req_chan.ready, vld_ff[0], "accepted word not in first stage")

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

   localparam int IDLE_LIMIT = 5000;
   localparam logic [31:0] ONE_BITS = 32'h3F800000;
   localparam logic [31:0] SIGN_BIT = 32'h80000000;

   logic clock;
   logic reset;

   vlfi_req_if req_chan ();
   vlfi_rsp_if rsp_chan ();

   vector_length_fast_isqrt uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic [31:0] length_queue[$];
   int          fail_count;
   int          vec2_count;
   int          vec3_count;
   int          length_count;
   int          idle_cycles;
   bit          send_gaps;
   bit          sink_stalls;
   int          stall_left;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ---------------- float32 arithmetic, round to nearest even ----------------

   function automatic vlfi_pkg::fkind_type fp_class(input logic [31:0] b);
      vlfi_pkg::fkind_type k;
      if (b[30:23] == 8'hFF) begin
         k = (b[22:0] != '0) ? vlfi_pkg::FK_NAN : vlfi_pkg::FK_INF;
      end else if (b[30:0] == '0) begin
         k = vlfi_pkg::FK_ZERO;
      end else begin
         k = vlfi_pkg::FK_NUM;
      end
      return k;
   endfunction

   function automatic logic [63:0] fp_mant(input logic [31:0] b);
      return {40'd0, b[30:23] != 8'd0, b[22:0]};
   endfunction

   function automatic int fp_exp(input logic [31:0] b);
      return (b[30:23] == 8'd0) ? -149 : int'(b[30:23]) - 150;
   endfunction

   // value = m * 2^e2, plus something below the lsb when sticky is set
   function automatic logic [31:0] fp_round(input logic sgn, input int e2,
                                            input logic [63:0] m, input logic sticky);
      int          p;
      int          ex;
      int          lsbx;
      int          sh;
      logic [63:0] keep;
      logic        half;
      logic        rest;
      if (m == '0) return {sgn, 31'd0};
      p = 0;
      for (int i = 0; i < 64; i++) if (m[i]) p = i;
      ex   = p + e2;
      lsbx = (ex < -126) ? -149 : ex - 23;
      sh   = lsbx - e2;
      if (sh > 64) begin
         keep = '0;
         half = 1'b0;
         rest = 1'b1;
      end else if (sh > 0) begin
         keep = m >> sh;
         half = m[sh-1];
         rest = sticky | ((m & ((64'd1 << (sh - 1)) - 64'd1)) != '0);
      end else begin
         keep = m << (-sh);
         half = 1'b0;
         rest = 1'b0;
      end
      if (half && (rest || keep[0])) keep = keep + 64'd1;
      if (keep[24]) begin
         keep = keep >> 1;
         lsbx++;
      end
      if (!keep[23]) return {sgn, 8'd0, keep[22:0]};
      if (lsbx + 150 >= 255) return {sgn, 8'hFF, 23'd0};
      return {sgn, 8'(lsbx + 150), keep[22:0]};
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      vlfi_pkg::fkind_type ka;
      vlfi_pkg::fkind_type kb;
      logic                s;
      ka = fp_class(a);
      kb = fp_class(b);
      s  = a[31] ^ b[31];
      if (ka == vlfi_pkg::FK_NAN || kb == vlfi_pkg::FK_NAN ||
          (ka == vlfi_pkg::FK_INF && kb == vlfi_pkg::FK_ZERO) ||
          (ka == vlfi_pkg::FK_ZERO && kb == vlfi_pkg::FK_INF)) return vlfi_pkg::CANON_NAN;
      if (ka == vlfi_pkg::FK_INF || kb == vlfi_pkg::FK_INF) return {s, 8'hFF, 23'd0};
      if (ka == vlfi_pkg::FK_ZERO || kb == vlfi_pkg::FK_ZERO) return {s, 31'd0};
      return fp_round(s, fp_exp(a) + fp_exp(b), fp_mant(a) * fp_mant(b), 1'b0);
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      vlfi_pkg::fkind_type ka;
      vlfi_pkg::fkind_type kb;
      logic [31:0]         hi;
      logic [31:0]         lo;
      int                  d;
      int                  k;
      int                  rsh;
      int                  base;
      logic [63:0]         av;
      logic [63:0]         bv;
      logic                st;
      ka = fp_class(a);
      kb = fp_class(b);
      if (ka == vlfi_pkg::FK_NAN || kb == vlfi_pkg::FK_NAN) return vlfi_pkg::CANON_NAN;
      if (ka == vlfi_pkg::FK_INF && kb == vlfi_pkg::FK_INF) begin
         return (a[31] != b[31]) ? vlfi_pkg::CANON_NAN : a;
      end
      if (ka == vlfi_pkg::FK_INF) return a;
      if (kb == vlfi_pkg::FK_INF) return b;
      if (ka == vlfi_pkg::FK_ZERO && kb == vlfi_pkg::FK_ZERO) return {a[31] & b[31], 31'd0};
      if (ka == vlfi_pkg::FK_ZERO) return b;
      if (kb == vlfi_pkg::FK_ZERO) return a;
      hi   = (a[30:0] < b[30:0]) ? b : a;
      lo   = (a[30:0] < b[30:0]) ? a : b;
      d    = fp_exp(hi) - fp_exp(lo);
      k    = (d > 30) ? 30 : d;
      rsh  = (d - k > 63) ? 63 : d - k;
      base = fp_exp(hi) - k;
      av   = fp_mant(hi) << k;
      bv   = fp_mant(lo) >> rsh;
      st   = (rsh > 0) && ((fp_mant(lo) & ((64'd1 << rsh) - 64'd1)) != '0);
      if (hi[31] == lo[31]) return fp_round(hi[31], base, av + bv, st);
      if (av == bv && !st) return 32'd0;
      // a dropped tail on the subtrahend borrows one lsb and leaves a tail
      if (st) return fp_round(hi[31], base, av - bv - 64'd1, 1'b1);
      return fp_round(hi[31], base, av - bv, 1'b0);
   endfunction

   function automatic logic [31:0] fp_recip(input logic [31:0] r);
      vlfi_pkg::fkind_type kr;
      logic [63:0]         q;
      logic [63:0]         rem;
      kr = fp_class(r);
      if (kr == vlfi_pkg::FK_NAN) return vlfi_pkg::CANON_NAN;
      if (kr == vlfi_pkg::FK_INF) return {r[31], 31'd0};
      if (kr == vlfi_pkg::FK_ZERO) return {r[31], 8'hFF, 23'd0};
      q   = (64'd1 << 60) / fp_mant(r);
      rem = (64'd1 << 60) % fp_mant(r);
      return fp_round(r[31], -60 - fp_exp(r), q, rem != '0);
   endfunction

   function automatic logic [31:0] predict_length(input logic cmd, input logic [31:0] x,
                                                  input logic [31:0] y, input logic [31:0] z);
      logic [31:0] sum_sq;
      logic [31:0] est;
      logic [31:0] h;
      logic [31:0] q;
      logic [31:0] corr;
      logic [31:0] len;
      sum_sq = fp_add(fp_mul(x, x), fp_mul(y, y));
      if (cmd == vlfi_pkg::CMD_VEC3) sum_sq = fp_add(sum_sq, fp_mul(z, z));
      est  = vlfi_pkg::ISQRT_MAGIC - {sum_sq[31], sum_sq[31:1]};
      h    = fp_mul(vlfi_pkg::HALF_BITS, sum_sq);
      q    = fp_mul(fp_mul(h, est), est);
      corr = fp_add(vlfi_pkg::THREE_HALVES, q ^ SIGN_BIT);
      len  = fp_recip(fp_mul(est, corr));
      if (len[30:23] == 8'hFF && len[22:0] != '0) len = vlfi_pkg::CANON_NAN;
      return len;
   endfunction

   // ---------------- result side ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= 0;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= stall_left - 1;
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                        : $urandom_range(0, 2);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         length_count++;
         if (length_queue.size() == 0) begin
            $error("length word with nothing outstanding: %h", rsp_chan.length_bits);
            fail_count++;
         end else begin
            want = length_queue.pop_front();
            if (rsp_chan.length_bits !== want) begin
               $error("length_bits expected %h actual %h", want, rsp_chan.length_bits);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles where neither channel moves a word
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d lengths outstanding", length_queue.size());
            $display("tb failed");
            $finish;
         end
      end
   end

   // ---------------- request side ----------------

   task automatic send_vector(input logic cmd, input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
      int gap;
      gap = 0;
      if (send_gaps && $urandom_range(0, 2) == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.command <= cmd;
      req_chan.x_bits  <= x;
      req_chan.y_bits  <= y;
      req_chan.z_bits  <= z;
      do @(posedge clock); while (!req_chan.ready);
      length_queue.push_back(predict_length(cmd, x, y, z));
      if (cmd == vlfi_pkg::CMD_VEC3) vec3_count++;
      else vec2_count++;
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (length_queue.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_component();
      logic [31:0] b;
      b = $urandom;
      case ($urandom_range(0, 11))
         0:       b = {b[31], 31'd0};
         1:       b = {b[31], 8'd0, b[22:0]};
         2:       b = {b[31], 8'hFF, 23'd0};
         3:       b = {b[31], 8'hFF, b[22:0] | 23'd1};
         4, 5:    ;
         6:       b = {b[31], 8'($urandom_range(1, 30)), b[22:0]};
         7:       b = {b[31], 8'($urandom_range(200, 254)), b[22:0]};
         default: b = {b[31], 8'($urandom_range(100, 154)), b[22:0]};
      endcase
      return b;
   endfunction

   task automatic test_directed();
      send_gaps   = 1'b0;
      sink_stalls = 1'b0;
      send_vector(1'b0, 32'h0, 32'h0, 32'h0);
      send_vector(1'b1, 32'h80000000, 32'h0, 32'h80000000);
      send_vector(1'b0, 32'h40400000, 32'h40800000, 32'h7FC00000);  // 3-4, z ignored
      send_vector(1'b1, 32'h40000000, 32'h40400000, 32'h40C00000);  // 2-3-6
      send_vector(1'b1, 32'hBF800000, ONE_BITS, 32'hBF800000);
      send_vector(1'b0, 32'h7F7FFFFF, 32'h0, 32'h0);
      send_vector(1'b1, 32'h5F000000, 32'h5F000000, 32'h5F000000);
      send_vector(1'b0, 32'h00000001, 32'h80000001, 32'h0);
      send_vector(1'b1, 32'h007FFFFF, 32'h00800000, 32'h00000001);
      send_vector(1'b0, 32'h1F800000, 32'h0, 32'h0);
      send_vector(1'b0, 32'h7F800000, ONE_BITS, 32'h0);
      send_vector(1'b1, 32'h0, 32'h0, 32'hFF800000);
      send_vector(1'b0, 32'h7FA00001, ONE_BITS, 32'h0);
      send_vector(1'b1, ONE_BITS, ONE_BITS, 32'hFFFFFFFF);
      send_vector(1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_vector(1'b1, 32'h7F800000, 32'hFF800000, 32'h7F800000);
      send_vector(1'b0, 32'h3F3504F3, 32'h3F3504F3, 32'h0);
      send_vector(1'b1, 32'h00000000, 32'h00000000, 32'h00000001);
      wait_drained();
   endtask

   task automatic test_random_stalls(input int count);
      send_gaps   = 1'b1;
      sink_stalls = 1'b1;
      for (int i = 0; i < count; i++) begin
         send_vector(1'($urandom), rand_component(), rand_component(), rand_component());
         // hold off now and then until the pipe is empty
         if ($urandom_range(0, 99) == 0) wait_drained();
      end
      wait_drained();
   endtask

   task automatic test_random_streaming(input int count);
      send_gaps   = 1'b0;
      sink_stalls = 1'b0;
      for (int i = 0; i < count; i++) begin
         send_vector(1'($urandom), $urandom, $urandom, $urandom);
      end
      sink_stalls = 1'b1;
      for (int i = 0; i < count; i++) begin
         send_vector(1'($urandom), rand_component(), rand_component(), rand_component());
      end
      wait_drained();
   endtask

   initial begin
      fail_count       = 0;
      vec2_count       = 0;
      vec3_count       = 0;
      length_count     = 0;
      send_gaps        = 1'b0;
      sink_stalls      = 1'b0;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.command = '0;
      req_chan.x_bits  = '0;
      req_chan.y_bits  = '0;
      req_chan.z_bits  = '0;
      rsp_chan.ready   = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_stalls(600);
      test_random_streaming(200);
      repeat (60) @(posedge clock);
      $display("covered %0d two-component and %0d three-component vectors, %0d lengths",
               vec2_count, vec3_count, length_count);
      $display("inputs spanned zeros, subnormals, infinities, nans and overflowing sums");
      if (fail_count == 0 && length_queue.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
